// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/bli_pkg.sv -----
// ----------------------------------------------------------------------------
// bli_pkg
// Types and constants of the bin locate and interpolate core.
// ----------------------------------------------------------------------------
package bli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int CNT_W       = 9;
    localparam int DATA_W      = 32;
    localparam int MAG_W       = 33;
    localparam int PROD_W      = 66;
    localparam int MUL_LO_W    = 17;
    localparam int QUOT_W      = 40;
    localparam int DIV_STEPS   = 33;
    localparam int STEP_W      = 6;

    typedef enum logic [1:0] {
        CMD_WR_EDGE  = 2'd0,
        CMD_WR_VALUE = 2'd1,
        CMD_QUERY    = 2'd2
    } t_cmd;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_LOWER = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_W,
        S_CONST_W,
        S_CEN_LO,
        S_CEN_HI,
        S_CEN_SUM,
        S_VAL_A,
        S_VAL_B,
        S_PREP,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_GO,
        S_DIV_W
    } t_state;

    typedef enum logic [2:0] {
        C_ZERO,
        C_LAST,
        C_IND,
        C_LEFT,
        C_RIGHT
    } t_cen;

    typedef struct packed {
        logic              done;
        logic              big;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

// ----- sv/bli_ram.sv -----
// ----------------------------------------------------------------------------
// bli_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bli_div.sv -----
// ----------------------------------------------------------------------------
// bli_div
// Restoring unsigned divider, two quotient bits per cycle, with an overflow
// flag for quotients that do not fit the kept width.
// ----------------------------------------------------------------------------
module bli_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bli_pkg::PROD_W-1:0]    i_dividend,
    input  logic [bli_pkg::MAG_W-1:0]     i_divisor,
    output bli_pkg::t_div_res             o_res
);

    logic                          r_busy;
    logic [bli_pkg::STEP_W-1:0]    r_cnt;
    logic [bli_pkg::PROD_W-1:0]    r_num;
    logic [bli_pkg::MAG_W-1:0]     r_den;
    logic [bli_pkg::MAG_W-1:0]     r_rem;
    logic [bli_pkg::QUOT_W-1:0]    r_quot;
    logic                          r_big;
    logic                          r_done;

    logic [bli_pkg::MAG_W-1:0]     n_rem;
    logic [bli_pkg::QUOT_W-1:0]    n_quot;
    logic                          n_big;

    always_comb begin
        logic [bli_pkg::MAG_W:0] v_sh;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_big  = r_big;
        for (int s = 0; s < 2; s++) begin
            v_sh   = {n_rem, r_num[bli_pkg::PROD_W-1-s]};
            n_big  = n_big | n_quot[bli_pkg::QUOT_W-1];
            if (v_sh >= {1'b0, r_den}) begin
                v_sh   = v_sh - {1'b0, r_den};
                n_quot = {n_quot[bli_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                n_quot = {n_quot[bli_pkg::QUOT_W-2:0], 1'b0};
            end
            n_rem = v_sh[bli_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bli_pkg::STEP_W'(bli_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bli_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_big  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[bli_pkg::PROD_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_big  <= n_big;
        end
    end

    assign o_res.done = r_done;
    assign o_res.big  = r_big;
    assign o_res.quot = r_quot;

endmodule

// ----- sv/bin_locate_interpolate_core.sv -----
// ----------------------------------------------------------------------------
// bin_locate_interpolate_core
// Bin lookup over ascending bin-top edges with constant or linear output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_cmd, i_slot, i_operand, taken when start is high and
//   busy is low. Edge and value writes complete in that cycle and give no
//   result. A query raises busy until its result is shown.
//   Result channel: o_bin_index, o_result_value, o_past_top, o_saturated,
//   valid for the single cycle in which o_done is high; the receiver cannot
//   stall, so the result is never held.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 mode, 1 edge count, 2 lower bound); write only while busy is low.
// Query steps: a constant mode query runs S binary search steps (up to 9,
//   each an edge RAM read and a compare), then reads the bin value and
//   shows it. Linear mode follows the search with up to five centre
//   evaluations, two value reads, a preparation step, two multiply steps,
//   a divider start and the divider run. The divider and the single read
//   port of each table set the length of a query.
// Throughput: one query at a time; busy falls in the cycle the result is
//   shown, so the next transaction can be taken then. Writes leave busy low.
// Reset: mode constant, edge count 1, lower bound at the negative limit;
//   table contents are undefined until written.
// ----------------------------------------------------------------------------
module bin_locate_interpolate_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_cmd,
    input  logic [bli_pkg::ADDR_W-1:0]     i_slot,
    input  logic signed [bli_pkg::DATA_W-1:0] i_operand,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [bli_pkg::DATA_W-1:0]     i_cfg_data,
    output logic                           o_done,
    output logic [bli_pkg::CNT_W-1:0]      o_bin_index,
    output logic signed [bli_pkg::DATA_W-1:0] o_result_value,
    output logic                           o_past_top,
    output logic                           o_saturated
);

    localparam int AW = bli_pkg::ADDR_W;
    localparam int CW = bli_pkg::CNT_W;
    localparam int DW = bli_pkg::DATA_W;
    localparam int MW = bli_pkg::MAG_W;
    localparam int PW = bli_pkg::PROD_W;
    localparam int LW = bli_pkg::MUL_LO_W;
    localparam int QW = bli_pkg::QUOT_W;
    localparam int SW = DW + QW - DW + 2;

    bli_pkg::t_state r_state, n_state;
    bli_pkg::t_cen   r_purp, n_purp;

    logic          r_mode;
    logic [CW-1:0] r_count;
    logic [DW-1:0] r_lower;

    logic [DW-1:0] r_x, n_x;
    logic [CW-1:0] r_n, n_n, r_lo, n_lo, r_hi, n_hi, r_ind, n_ind;
    logic [AW-1:0] r_k, n_k, r_i1, n_i1;
    logic [DW-1:0] r_clo, n_clo, r_xl, n_xl, r_xr, n_xr, r_yl, n_yl, r_yr, n_yr;
    logic          r_neg, n_neg;
    logic [MW-1:0] r_mdx, n_mdx, r_mdy, n_mdy, r_mdv, n_mdv;
    logic [PW-1:0] r_prod, n_prod;
    logic          r_done, n_done, r_past, n_past, r_sat, n_sat;
    logic [CW-1:0] r_bin, n_bin;
    logic [DW-1:0] r_val, n_val;

    logic          e_we, v_we, div_go;
    logic [AW-1:0] e_raddr, v_raddr;
    logic [DW-1:0] e_rdata, v_rdata;
    bli_pkg::t_div_res div_res;

    logic          accept, is_query, linear, x_le_c, x_ge_c, x_lt_c;
    logic [CW-1:0] n_clamp, mid;
    logic [CW:0]   lohi;
    logic [DW:0]   cen_sum, dx, dy, dv;
    logic [DW-1:0] cen;
    logic [MW+LW-1:0] mul_p;
    logic [LW-1:0] mul_b;
    logic [SW-1:0] fin_sum;

    assign busy     = (r_state != bli_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign is_query = (i_cmd == bli_pkg::CMD_QUERY);
    assign e_we     = accept && (i_cmd == bli_pkg::CMD_WR_EDGE);
    assign v_we     = accept && (i_cmd == bli_pkg::CMD_WR_VALUE);
    assign linear   = r_mode && (r_n != CW'(1));

    assign n_clamp = (r_count == '0) ? CW'(1) :
                     (r_count > CW'(bli_pkg::TABLE_DEPTH)) ? CW'(bli_pkg::TABLE_DEPTH) :
                     r_count;

    assign lohi    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = lohi[CW:1];
    assign cen_sum = {r_clo[DW-1], r_clo} + {e_rdata[DW-1], e_rdata};
    assign cen     = cen_sum[DW:1];
    assign x_le_c  = $signed(r_x) <= $signed(cen);
    assign x_ge_c  = $signed(r_x) >= $signed(cen);
    assign x_lt_c  = $signed(r_x) < $signed(cen);

    assign dx = {r_xr[DW-1], r_xr} - {r_xl[DW-1], r_xl};
    assign dy = {r_yr[DW-1], r_yr} - {r_yl[DW-1], r_yl};
    assign dv = {r_x[DW-1], r_x} - {r_xl[DW-1], r_xl};

    assign mul_b = (r_state == bli_pkg::S_MUL_HI) ? LW'(r_mdv[MW-1:LW]) : r_mdv[LW-1:0];
    assign mul_p = r_mdy * mul_b;

    assign fin_sum = r_neg ? {{(SW-DW){r_yl[DW-1]}}, r_yl} - SW'(div_res.quot)
                           : {{(SW-DW){r_yl[DW-1]}}, r_yl} + SW'(div_res.quot);

    bli_ram #(.WIDTH(DW), .DEPTH(bli_pkg::TABLE_DEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (i_slot),
        .i_wdata (i_operand),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    bli_ram #(.WIDTH(DW), .DEPTH(bli_pkg::TABLE_DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (i_slot),
        .i_wdata (i_operand),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    bli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_prod),
        .i_divisor  (r_mdx),
        .o_res      (div_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            bli_pkg::S_IDLE:    if (accept && is_query) n_state = bli_pkg::S_SRCH;
            bli_pkg::S_SRCH: begin
                if (r_lo < r_hi) n_state = bli_pkg::S_SRCH_W;
                else if (linear) n_state = bli_pkg::S_CEN_LO;
                else n_state = bli_pkg::S_CONST_W;
            end
            bli_pkg::S_SRCH_W:  n_state = bli_pkg::S_SRCH;
            bli_pkg::S_CONST_W: n_state = bli_pkg::S_IDLE;
            bli_pkg::S_CEN_LO:  n_state = bli_pkg::S_CEN_HI;
            bli_pkg::S_CEN_HI:  n_state = bli_pkg::S_CEN_SUM;
            bli_pkg::S_CEN_SUM: begin
                if (r_purp == bli_pkg::C_RIGHT) n_state = bli_pkg::S_VAL_A;
                else n_state = bli_pkg::S_CEN_LO;
            end
            bli_pkg::S_VAL_A:   n_state = bli_pkg::S_VAL_B;
            bli_pkg::S_VAL_B:   n_state = bli_pkg::S_PREP;
            bli_pkg::S_PREP: begin
                if (dx == '0) n_state = bli_pkg::S_IDLE;
                else n_state = bli_pkg::S_MUL_LO;
            end
            bli_pkg::S_MUL_LO:  n_state = bli_pkg::S_MUL_HI;
            bli_pkg::S_MUL_HI:  n_state = bli_pkg::S_DIV_GO;
            bli_pkg::S_DIV_GO:  n_state = bli_pkg::S_DIV_W;
            bli_pkg::S_DIV_W:   if (div_res.done) n_state = bli_pkg::S_IDLE;
            default:            n_state = bli_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_x = r_x; n_n = r_n; n_lo = r_lo; n_hi = r_hi; n_ind = r_ind;
        n_k = r_k; n_i1 = r_i1; n_purp = r_purp; n_clo = r_clo;
        n_xl = r_xl; n_xr = r_xr; n_yl = r_yl; n_yr = r_yr;
        n_neg = r_neg; n_mdx = r_mdx; n_mdy = r_mdy; n_mdv = r_mdv; n_prod = r_prod;
        n_done = 1'b0; n_bin = r_bin; n_val = r_val; n_past = r_past; n_sat = r_sat;
        e_raddr = mid[AW-1:0];
        v_raddr = r_i1;
        div_go  = 1'b0;
        case (r_state)
            bli_pkg::S_IDLE: begin
                n_x  = i_operand;
                n_n  = n_clamp;
                n_lo = '0;
                n_hi = n_clamp;
            end
            bli_pkg::S_SRCH: begin
                n_ind  = r_lo;
                n_k    = '0;
                n_purp = bli_pkg::C_ZERO;
                v_raddr = (r_lo < r_n) ? r_lo[AW-1:0] : AW'(r_n - CW'(1));
            end
            bli_pkg::S_SRCH_W: begin
                if ($signed(e_rdata) > $signed(r_x)) n_hi = mid;
                else n_lo = mid + CW'(1);
            end
            bli_pkg::S_CONST_W: begin
                n_done = 1'b1;
                n_bin  = r_ind;
                n_past = (r_ind == r_n);
                n_val  = v_rdata;
                n_sat  = 1'b0;
            end
            bli_pkg::S_CEN_LO: begin
                e_raddr = r_k - AW'(1);
            end
            bli_pkg::S_CEN_HI: begin
                n_clo   = (r_k == '0) ? r_lower : e_rdata;
                e_raddr = r_k;
            end
            bli_pkg::S_CEN_SUM: begin
                case (r_purp)
                    bli_pkg::C_ZERO: begin
                        if (r_ind == '0 || x_le_c) begin
                            n_i1 = '0; n_k = '0; n_purp = bli_pkg::C_LEFT;
                        end else begin
                            n_k = AW'(r_n - CW'(1)); n_purp = bli_pkg::C_LAST;
                        end
                    end
                    bli_pkg::C_LAST: begin
                        if (r_ind == r_n || x_ge_c) begin
                            n_i1 = AW'(r_n - CW'(2)); n_k = AW'(r_n - CW'(2));
                            n_purp = bli_pkg::C_LEFT;
                        end else begin
                            n_k = r_ind[AW-1:0]; n_purp = bli_pkg::C_IND;
                        end
                    end
                    bli_pkg::C_IND: begin
                        n_i1 = x_lt_c ? AW'(r_ind - CW'(1)) : r_ind[AW-1:0];
                        n_k  = n_i1;
                        n_purp = bli_pkg::C_LEFT;
                    end
                    bli_pkg::C_LEFT: begin
                        n_xl = cen;
                        n_k  = r_i1 + AW'(1);
                        n_purp = bli_pkg::C_RIGHT;
                    end
                    default: begin
                        n_xr = cen;
                    end
                endcase
            end
            bli_pkg::S_VAL_A: begin
                n_yl    = v_rdata;
                v_raddr = r_i1 + AW'(1);
            end
            bli_pkg::S_VAL_B: begin
                n_yr = v_rdata;
            end
            bli_pkg::S_PREP: begin
                n_neg = dx[DW] ^ dy[DW] ^ dv[DW];
                n_mdx = dx[DW] ? MW'(-dx) : MW'(dx);
                n_mdy = dy[DW] ? MW'(-dy) : MW'(dy);
                n_mdv = dv[DW] ? MW'(-dv) : MW'(dv);
                if (dx == '0) begin
                    n_done = 1'b1;
                    n_bin  = r_ind;
                    n_past = (r_ind == r_n);
                    n_val  = r_yl;
                    n_sat  = 1'b0;
                end
            end
            bli_pkg::S_MUL_LO: begin
                n_prod = PW'(mul_p);
            end
            bli_pkg::S_MUL_HI: begin
                n_prod = r_prod + (PW'(mul_p) << LW);
            end
            bli_pkg::S_DIV_GO: begin
                div_go = 1'b1;
            end
            bli_pkg::S_DIV_W: begin
                if (div_res.done) begin
                    n_done = 1'b1;
                    n_bin  = r_ind;
                    n_past = (r_ind == r_n);
                    if (div_res.big) begin
                        n_sat = 1'b1;
                        n_val = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                    end else if (fin_sum[SW-1] && !(&fin_sum[SW-2:DW-1])) begin
                        n_sat = 1'b1;
                        n_val = {1'b1, {(DW-1){1'b0}}};
                    end else if (!fin_sum[SW-1] && (|fin_sum[SW-2:DW-1])) begin
                        n_sat = 1'b1;
                        n_val = {1'b0, {(DW-1){1'b1}}};
                    end else begin
                        n_sat = 1'b0;
                        n_val = fin_sum[DW-1:0];
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bli_pkg::S_IDLE;
            r_purp  <= bli_pkg::C_ZERO;
            r_done  <= 1'b0;
            r_mode  <= 1'b0;
            r_count <= CW'(1);
            r_lower <= {1'b1, {(DW-1){1'b0}}};
        end else begin
            r_state <= n_state;
            r_purp  <= n_purp;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bli_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    bli_pkg::CFG_COUNT: r_count <= i_cfg_data[CW-1:0];
                    bli_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                    default:            r_mode  <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_n <= n_n; r_lo <= n_lo; r_hi <= n_hi; r_ind <= n_ind;
        r_k <= n_k; r_i1 <= n_i1; r_clo <= n_clo;
        r_xl <= n_xl; r_xr <= n_xr; r_yl <= n_yl; r_yr <= n_yr;
        r_neg <= n_neg; r_mdx <= n_mdx; r_mdy <= n_mdy; r_mdv <= n_mdv;
        r_prod <= n_prod;
        r_bin <= n_bin; r_val <= n_val; r_past <= n_past; r_sat <= n_sat;
    end

    assign o_done         = r_done;
    assign o_bin_index    = r_bin;
    assign o_result_value = r_val;
    assign o_past_top     = r_past;
    assign o_saturated    = r_sat;

endmodule

// ----- sv/bli_checker.sv -----
// ----------------------------------------------------------------------------
// bli_checker
// Port-level checks of the bin locate and interpolate core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bli_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_cmd,
    input logic       o_done
);

    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_cmd == bli_pkg::CMD_QUERY, busy && !o_done)
    `ASSERT_NEXT(a_write_free, i_clk, i_rst_n, start && !busy && i_cmd != bli_pkg::CMD_QUERY, !busy && !o_done)

endmodule

bind bin_locate_interpolate_core bli_checker u_bli_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_done  (o_done)
);
